// ===== rtl/core/rtcsc_pkg.sv =====
// ----------------------------------------------------------------------------
// rtcsc_pkg
// Shared constants and item codes of the real-time clock with seconds
// counter and alarm.
// ----------------------------------------------------------------------------
package rtcsc_pkg;

    localparam int COUNT_W    = 32;
    localparam int PRESCALE_W = 20;
    localparam int TOD_W      = 17;

    localparam logic [PRESCALE_W-1:0] RELOAD_AT_RESET = 20'd32767;

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

    // floor(2^48 / 86400), quotient may come out one low
    localparam logic [31:0] DAY_RECIP = 32'd3257812230;
    // exact for values below 86400, quotient in bits [31:27]
    localparam logic [15:0] HOUR_RECIP = 16'd37283;
    // exact for values below 3600, quotient in bits [23:18]
    localparam logic [12:0] MIN_RECIP = 13'd4370;

    localparam logic [4:0] LAST_HOUR   = 5'd23;
    localparam logic [5:0] LAST_MINUTE = 6'd59;
    localparam logic [5:0] LAST_SECOND = 6'd59;

    typedef enum logic [2:0] {
        MODE_TICK        = 3'd0,
        MODE_SET_COUNT   = 3'd1,
        MODE_SET_TIME    = 3'd2,
        MODE_ALARM_ABS   = 3'd3,
        MODE_ALARM_REL   = 3'd4,
        MODE_ALARM_TOD   = 3'd5,
        MODE_CLEAR_FLAG  = 3'd6
    } mode_t;

endpackage

// ===== rtl/core/rtc_seconds_counter_alarm_top.sv =====
// ----------------------------------------------------------------------------
// rtc_seconds_counter_alarm_top
// Real-time clock: a tick prescaler drives a 32-bit seconds counter that is
// compared against an alarm value; items also set the counter, set the alarm
// and clear the sticky alarm flag. Every item gives one result with the
// count, its time of day, the seconds left until the alarm and the flag.
// One item is taken per clock while the output is not stalled. Items go
// through a pipeline of registered stages: two stages take the item's value
// modulo 86400 by reciprocal multiplication, one stage updates the clock
// state (prescaler, counter, time of day, alarm, flag) so back to back items
// see each other's effect, and four stages split the time of day into hours,
// minutes and seconds and form the time to the alarm, ahead of a result
// register. Each stage holds its item only while the next one is full, so
// bubbles close up under output backpressure. The prescaler reload register
// is written through cfg_wr_en and cfg_wr_data and is loaded into the
// prescaler by the next tick that finds the prescaler at zero.
// ----------------------------------------------------------------------------
module rtc_seconds_counter_alarm_top
    import rtcsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  cfg_wr_en,
    input  logic [PRESCALE_W-1:0] cfg_wr_data,

    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            mode,
    input  logic [COUNT_W-1:0]    value,
    input  logic [4:0]            hour_in,
    input  logic [5:0]            minute_in,
    input  logic [5:0]            second_in,

    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COUNT_W-1:0]    count_now,
    output logic [4:0]            hour_out,
    output logic [5:0]            minute_out,
    output logic [5:0]            second_out,
    output logic [COUNT_W-1:0]    seconds_until_alarm,
    output logic                  alarm_flag_out,
    output logic                  alarm_hit
);

    // stage load enables
    logic ld1, ld2, ld3, ld4, ld5, ld6, ld7, ld_out;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic s5_valid_reg, s6_valid_reg, s7_valid_reg, out_valid_reg;

    // stage 1: input register
    logic [2:0]         s1_mode_reg;
    logic [COUNT_W-1:0] s1_value_reg;
    logic [4:0]         s1_hour_reg;
    logic [5:0]         s1_minute_reg;
    logic [5:0]         s1_second_reg;
    logic [63:0]        s1_day_prod;
    logic [15:0]        s1_quot;
    logic [TOD_W-1:0]   s1_ds;
    logic [TOD_W-1:0]   s1_ds_tod;

    // stage 2: remainder of value by one day
    logic [2:0]         s2_mode_reg;
    logic [COUNT_W-1:0] s2_value_reg;
    logic [15:0]        s2_quot_reg;
    logic [TOD_W-1:0]   s2_ds_reg;
    logic [TOD_W-1:0]   s2_ds_tod_reg;
    logic [COUNT_W-1:0] s2_quot_secs;
    logic [COUNT_W-1:0] s2_rem_wide;
    logic [17:0]        s2_rem;
    logic [TOD_W-1:0]   s2_value_tod;

    // stage 3: clock state update
    logic [2:0]         s3_mode_reg;
    logic [COUNT_W-1:0] s3_value_reg;
    logic [TOD_W-1:0]   s3_value_tod_reg;
    logic [TOD_W-1:0]   s3_ds_reg;
    logic [TOD_W-1:0]   s3_ds_tod_reg;

    logic [PRESCALE_W-1:0] reload_reg;
    logic [PRESCALE_W-1:0] prescale_reg, prescale_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [TOD_W-1:0]      tod_reg, tod_next;
    logic [COUNT_W-1:0]    alarm_reg, alarm_next;
    logic                  flag_reg, flag_next;
    logic                  hit_next;
    logic [COUNT_W-1:0]    count_inc;
    logic [17:0]           target_adj;
    logic [17:0]           alarm_step;

    // stage 4: time to alarm and hour
    logic [COUNT_W-1:0] s4_count_reg;
    logic [COUNT_W-1:0] s4_alarm_reg;
    logic               s4_flag_reg;
    logic               s4_hit_reg;
    logic [TOD_W-1:0]   s4_tod_reg;
    logic [COUNT_W-1:0] s4_until;
    logic [32:0]        s4_hour_prod;

    // stage 5: seconds within the hour
    logic [COUNT_W-1:0] s5_count_reg;
    logic [COUNT_W-1:0] s5_until_reg;
    logic               s5_flag_reg;
    logic               s5_hit_reg;
    logic [4:0]         s5_hour_reg;
    logic [TOD_W-1:0]   s5_tod_reg;
    logic [TOD_W-1:0]   s5_hour_secs;
    logic [TOD_W-1:0]   s5_rem_wide;

    // stage 6: minute
    logic [COUNT_W-1:0] s6_count_reg;
    logic [COUNT_W-1:0] s6_until_reg;
    logic               s6_flag_reg;
    logic               s6_hit_reg;
    logic [4:0]         s6_hour_reg;
    logic [11:0]        s6_rem_reg;
    logic [24:0]        s6_min_prod;

    // stage 7: second
    logic [COUNT_W-1:0] s7_count_reg;
    logic [COUNT_W-1:0] s7_until_reg;
    logic               s7_flag_reg;
    logic               s7_hit_reg;
    logic [4:0]         s7_hour_reg;
    logic [5:0]         s7_minute_reg;
    logic [11:0]        s7_rem_reg;
    logic [11:0]        s7_min_secs;
    logic [11:0]        s7_second_wide;

    // result register
    logic [COUNT_W-1:0] out_count_reg;
    logic [COUNT_W-1:0] out_until_reg;
    logic               out_flag_reg;
    logic               out_hit_reg;
    logic [4:0]         out_hour_reg;
    logic [5:0]         out_minute_reg;
    logic [5:0]         out_second_reg;

    assign ld_out   = !out_valid_reg || out_ready;
    assign ld7      = !s7_valid_reg || ld_out;
    assign ld6      = !s6_valid_reg || ld7;
    assign ld5      = !s5_valid_reg || ld6;
    assign ld4      = !s4_valid_reg || ld5;
    assign ld3      = !s3_valid_reg || ld4;
    assign ld2      = !s2_valid_reg || ld3;
    assign ld1      = !s1_valid_reg || ld2;
    assign in_ready = ld1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            s6_valid_reg  <= 1'b0;
            s7_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ld1)    s1_valid_reg  <= in_valid;
            if (ld2)    s2_valid_reg  <= s1_valid_reg;
            if (ld3)    s3_valid_reg  <= s2_valid_reg;
            if (ld4)    s4_valid_reg  <= s3_valid_reg;
            if (ld5)    s5_valid_reg  <= s4_valid_reg;
            if (ld6)    s6_valid_reg  <= s5_valid_reg;
            if (ld7)    s7_valid_reg  <= s6_valid_reg;
            if (ld_out) out_valid_reg <= s7_valid_reg;
        end
    end

    // stage 1 logic
    assign s1_day_prod = {32'd0, s1_value_reg} * {32'd0, DAY_RECIP};
    assign s1_quot     = s1_day_prod[63:48];
    assign s1_ds       = TOD_W'(s1_hour_reg) * TOD_W'(SECS_PER_HOUR)
                       + TOD_W'(s1_minute_reg) * TOD_W'(SECS_PER_MIN)
                       + TOD_W'(s1_second_reg);
    assign s1_ds_tod   = (s1_ds >= SECS_PER_DAY) ? (s1_ds - SECS_PER_DAY) : s1_ds;

    // stage 2 logic: quotient may be one low, one correction
    assign s2_quot_secs = COUNT_W'(s2_quot_reg) * COUNT_W'(SECS_PER_DAY);
    assign s2_rem_wide  = s2_value_reg - s2_quot_secs;
    assign s2_rem       = s2_rem_wide[17:0];
    assign s2_value_tod = (s2_rem >= 18'(SECS_PER_DAY))
                        ? TOD_W'(s2_rem - 18'(SECS_PER_DAY))
                        : s2_rem[TOD_W-1:0];

    // stage 3 logic: clock state
    assign count_inc  = count_reg + 32'd1;
    assign target_adj = (s3_ds_reg <= tod_reg)
                      ? (18'(s3_ds_reg) + 18'(SECS_PER_DAY))
                      : 18'(s3_ds_reg);
    assign alarm_step = target_adj - 18'(tod_reg);

    always_comb
    begin
        prescale_next = prescale_reg;
        count_next    = count_reg;
        tod_next      = tod_reg;
        alarm_next    = alarm_reg;
        flag_next     = flag_reg;
        hit_next      = 1'b0;
        case (s3_mode_reg)
            MODE_TICK:
            begin
                if (prescale_reg == '0)
                begin
                    prescale_next = reload_reg;
                    count_next    = count_inc;
                    if (count_inc == '0 || tod_reg == SECS_PER_DAY - 17'd1)
                        tod_next = '0;
                    else
                        tod_next = tod_reg + 17'd1;
                    if (count_inc == alarm_reg)
                    begin
                        hit_next  = 1'b1;
                        flag_next = 1'b1;
                    end
                end
                else
                begin
                    prescale_next = prescale_reg - 20'd1;
                end
            end
            MODE_SET_COUNT:
            begin
                count_next = s3_value_reg;
                tod_next   = s3_value_tod_reg;
            end
            MODE_SET_TIME:
            begin
                count_next = COUNT_W'(s3_ds_reg);
                tod_next   = s3_ds_tod_reg;
            end
            MODE_ALARM_ABS:
            begin
                alarm_next = s3_value_reg;
            end
            MODE_ALARM_REL:
            begin
                alarm_next = count_reg + s3_value_reg;
            end
            MODE_ALARM_TOD:
            begin
                alarm_next = count_reg + COUNT_W'(alarm_step);
            end
            MODE_CLEAR_FLAG:
            begin
                flag_next = 1'b0;
            end
            default:
            begin
                flag_next = flag_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg   <= RELOAD_AT_RESET;
            prescale_reg <= RELOAD_AT_RESET;
            count_reg    <= '0;
            tod_reg      <= '0;
            alarm_reg    <= '1;
            flag_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                reload_reg <= cfg_wr_data;
            if (s3_valid_reg && ld4)
            begin
                prescale_reg <= prescale_next;
                count_reg    <= count_next;
                tod_reg      <= tod_next;
                alarm_reg    <= alarm_next;
                flag_reg     <= flag_next;
            end
        end
    end

    // stage 4 logic
    assign s4_until     = (s4_alarm_reg > s4_count_reg) ? (s4_alarm_reg - s4_count_reg) : '0;
    assign s4_hour_prod = 33'(s4_tod_reg) * 33'(HOUR_RECIP);

    // stage 5 logic
    assign s5_hour_secs = TOD_W'(s5_hour_reg) * TOD_W'(SECS_PER_HOUR);
    assign s5_rem_wide  = s5_tod_reg - s5_hour_secs;

    // stage 6 logic
    assign s6_min_prod = 25'(s6_rem_reg) * 25'(MIN_RECIP);

    // stage 7 logic
    assign s7_min_secs    = 12'(s7_minute_reg) * 12'(SECS_PER_MIN);
    assign s7_second_wide = s7_rem_reg - s7_min_secs;

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ld1 && in_valid)
        begin
            s1_mode_reg   <= mode;
            s1_value_reg  <= value;
            s1_hour_reg   <= hour_in;
            s1_minute_reg <= minute_in;
            s1_second_reg <= second_in;
        end
        if (ld2 && s1_valid_reg)
        begin
            s2_mode_reg   <= s1_mode_reg;
            s2_value_reg  <= s1_value_reg;
            s2_quot_reg   <= s1_quot;
            s2_ds_reg     <= s1_ds;
            s2_ds_tod_reg <= s1_ds_tod;
        end
        if (ld3 && s2_valid_reg)
        begin
            s3_mode_reg      <= s2_mode_reg;
            s3_value_reg     <= s2_value_reg;
            s3_value_tod_reg <= s2_value_tod;
            s3_ds_reg        <= s2_ds_reg;
            s3_ds_tod_reg    <= s2_ds_tod_reg;
        end
        if (ld4 && s3_valid_reg)
        begin
            s4_count_reg <= count_next;
            s4_alarm_reg <= alarm_next;
            s4_flag_reg  <= flag_next;
            s4_hit_reg   <= hit_next;
            s4_tod_reg   <= tod_next;
        end
        if (ld5 && s4_valid_reg)
        begin
            s5_count_reg <= s4_count_reg;
            s5_until_reg <= s4_until;
            s5_flag_reg  <= s4_flag_reg;
            s5_hit_reg   <= s4_hit_reg;
            s5_hour_reg  <= s4_hour_prod[31:27];
            s5_tod_reg   <= s4_tod_reg;
        end
        if (ld6 && s5_valid_reg)
        begin
            s6_count_reg <= s5_count_reg;
            s6_until_reg <= s5_until_reg;
            s6_flag_reg  <= s5_flag_reg;
            s6_hit_reg   <= s5_hit_reg;
            s6_hour_reg  <= s5_hour_reg;
            s6_rem_reg   <= s5_rem_wide[11:0];
        end
        if (ld7 && s6_valid_reg)
        begin
            s7_count_reg  <= s6_count_reg;
            s7_until_reg  <= s6_until_reg;
            s7_flag_reg   <= s6_flag_reg;
            s7_hit_reg    <= s6_hit_reg;
            s7_hour_reg   <= s6_hour_reg;
            s7_minute_reg <= s6_min_prod[23:18];
            s7_rem_reg    <= s6_rem_reg;
        end
        if (ld_out && s7_valid_reg)
        begin
            out_count_reg  <= s7_count_reg;
            out_until_reg  <= s7_until_reg;
            out_flag_reg   <= s7_flag_reg;
            out_hit_reg    <= s7_hit_reg;
            out_hour_reg   <= s7_hour_reg;
            out_minute_reg <= s7_minute_reg;
            out_second_reg <= s7_second_wide[5:0];
        end
    end

    assign out_valid           = out_valid_reg;
    assign count_now           = out_count_reg;
    assign hour_out            = out_hour_reg;
    assign minute_out          = out_minute_reg;
    assign second_out          = out_second_reg;
    assign seconds_until_alarm = out_until_reg;
    assign alarm_flag_out      = out_flag_reg;
    assign alarm_hit           = out_hit_reg;

endmodule

// ===== rtl/core/rtcsc_checker.sv =====
// ----------------------------------------------------------------------------
// rtcsc_checker
// Port-level checks of the real-time clock results, bound to the top level.
// ----------------------------------------------------------------------------
module rtcsc_checker
    import rtcsc_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input logic [COUNT_W-1:0] count_now,
    input logic [4:0]         hour_out,
    input logic [5:0]         minute_out,
    input logic [5:0]         second_out,
    input logic [COUNT_W-1:0] seconds_until_alarm,
    input logic               alarm_flag_out,
    input logic               alarm_hit
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(count_now)
                                    && $stable(seconds_until_alarm))
        else $error("result changed while stalled");

    // time of day split stays in range
    a_tod_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> hour_out <= LAST_HOUR && minute_out <= LAST_MINUTE
                      && second_out <= LAST_SECOND)
        else $error("time of day field out of range");

    // a hit sets the sticky flag
    a_hit_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && alarm_hit |-> alarm_flag_out)
        else $error("alarm hit without flag");

    // a hit means the count reached the alarm
    a_hit_until: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && alarm_hit |-> seconds_until_alarm == '0)
        else $error("alarm hit with time left");

endmodule

bind rtc_seconds_counter_alarm_top rtcsc_checker u_rtcsc_checker (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the real-time clock with seconds counter and
// alarm. A queue of clock commands feeds a valid/ready driver, and a local
// model of the prescaler, counter, alarm and flag predicts each report. The
// monitor compares every report transfer field by field. Directed commands
// cover the prescaler run-down after reset, counter wrap, alarm hits and
// every alarm mode. Random scenarios follow under several reload values,
// with random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
    import rtcsc_pkg::*;

    localparam logic [2:0] MODE_UNUSED = 3'd7;

    typedef struct {
        logic [2:0]         mode;
        logic [COUNT_W-1:0] value;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [5:0]         second;
    } clock_cmd_t;

    typedef struct {
        logic [COUNT_W-1:0] count;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [5:0]         second;
        logic [COUNT_W-1:0] to_alarm;
        logic               flag;
        logic               hit;
    } clock_report_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [PRESCALE_W-1:0] cfg_wr_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [2:0]            mode = '0;
    logic [COUNT_W-1:0]    value = '0;
    logic [4:0]            hour_in = '0;
    logic [5:0]            minute_in = '0;
    logic [5:0]            second_in = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [COUNT_W-1:0]    count_now;
    logic [4:0]            hour_out;
    logic [5:0]            minute_out;
    logic [5:0]            second_out;
    logic [COUNT_W-1:0]    seconds_until_alarm;
    logic                  alarm_flag_out;
    logic                  alarm_hit;

    clock_cmd_t    clock_cmds[$];
    clock_report_t clock_reports_due[$];
    int unsigned   cmds_queued = 0;
    int unsigned   fault_count = 0;
    logic          in_taken = 1'b0;
    logic          fast_feed = 1'b0;
    int unsigned   feed_gap = 0;
    int unsigned   feed_calm = 0;
    int unsigned   stall_left = 0;
    int unsigned   sink_calm = 0;

    logic [PRESCALE_W-1:0] rtc_reload = RELOAD_AT_RESET;
    logic [PRESCALE_W-1:0] rtc_prescale = RELOAD_AT_RESET;
    logic [COUNT_W-1:0]    rtc_seconds = '0;
    logic [COUNT_W-1:0]    rtc_alarm = '1;
    logic                  rtc_flag = 1'b0;

    rtc_seconds_counter_alarm_top dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .mode                (mode),
        .value               (value),
        .hour_in             (hour_in),
        .minute_in           (minute_in),
        .second_in           (second_in),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .count_now           (count_now),
        .hour_out            (hour_out),
        .minute_out          (minute_out),
        .second_out          (second_out),
        .seconds_until_alarm (seconds_until_alarm),
        .alarm_flag_out      (alarm_flag_out),
        .alarm_hit           (alarm_hit)
    );

    always #4 clk = ~clk;

    function automatic logic [COUNT_W-1:0] day_offset(input logic [4:0] h, input logic [5:0] m,
                                                      input logic [5:0] s);
        day_offset = 32'(h) * SECS_PER_HOUR + 32'(m) * SECS_PER_MIN + 32'(s);
    endfunction

    function automatic clock_report_t rtc_advance(input clock_cmd_t cmd);
        clock_report_t      r;
        logic [COUNT_W-1:0] target;
        logic [COUNT_W-1:0] tod;
        r.hit = 1'b0;
        case (cmd.mode)
            MODE_TICK:
            begin
                if (rtc_prescale == '0)
                begin
                    rtc_prescale = rtc_reload;
                    rtc_seconds = rtc_seconds + 32'd1;
                    if (rtc_seconds == rtc_alarm)
                    begin
                        rtc_flag = 1'b1;
                        r.hit = 1'b1;
                    end
                end
                else
                begin
                    rtc_prescale = rtc_prescale - 1'b1;
                end
            end
            MODE_SET_COUNT:  rtc_seconds = cmd.value;
            MODE_SET_TIME:   rtc_seconds = day_offset(cmd.hour, cmd.minute, cmd.second);
            MODE_ALARM_ABS:  rtc_alarm = cmd.value;
            MODE_ALARM_REL:  rtc_alarm = rtc_seconds + cmd.value;
            MODE_ALARM_TOD:
            begin
                target = day_offset(cmd.hour, cmd.minute, cmd.second);
                tod = rtc_seconds % SECS_PER_DAY;
                if (target <= tod)
                begin
                    target = target + SECS_PER_DAY;
                end
                rtc_alarm = rtc_seconds - tod + target;
            end
            MODE_CLEAR_FLAG: rtc_flag = 1'b0;
            default: ;
        endcase
        tod = rtc_seconds % SECS_PER_DAY;
        r.count = rtc_seconds;
        r.hour = 5'(tod / SECS_PER_HOUR);
        r.minute = 6'((tod % SECS_PER_HOUR) / SECS_PER_MIN);
        r.second = 6'(tod % SECS_PER_MIN);
        r.to_alarm = (rtc_alarm > rtc_seconds) ? rtc_alarm - rtc_seconds : '0;
        r.flag = rtc_flag;
        return r;
    endfunction

    function automatic int unsigned pick_gap(inout int unsigned calm);
        int unsigned r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 2)
        begin
            calm = $urandom_range(20, 60);
            return 0;
        end
        if (r < 65)
        begin
            return 0;
        end
        if (r < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic void push_cmd(input logic [2:0] md, input logic [COUNT_W-1:0] val,
                                     input logic [4:0] h, input logic [5:0] m,
                                     input logic [5:0] s);
        clock_cmd_t cmd;
        cmd.mode = md;
        cmd.value = val;
        cmd.hour = h;
        cmd.minute = m;
        cmd.second = s;
        clock_cmds.push_back(cmd);
        cmds_queued++;
    endfunction

    function automatic void push_any(input logic [2:0] md, input logic [COUNT_W-1:0] val);
        push_cmd(md, val, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)),
                 6'($urandom_range(0, 63)));
    endfunction

    function automatic void push_ticks(input int unsigned n);
        repeat (n) push_any(MODE_TICK, $urandom);
    endfunction

    function automatic logic [COUNT_W-1:0] random_count();
        case ($urandom_range(0, 2))
            0:       return $urandom;
            1:       return $urandom_range(0, 200000);
            default: return 32'hFFFF_FFFF - $urandom_range(0, 5);
        endcase
    endfunction

    function automatic void push_scenario(input logic [PRESCALE_W-1:0] reload);
        int unsigned        span;
        int unsigned        k;
        int unsigned        t;
        logic [COUNT_W-1:0] c;
        span = (reload > 7) ? 1 : reload + 1;
        k = $urandom_range(1, 4);
        c = random_count();
        case ($urandom_range(0, 9))
            0, 1:
            begin
                push_any(MODE_SET_COUNT, c);
                push_any(MODE_ALARM_REL, k);
                push_ticks((k + 1) * span + $urandom_range(0, 2));
            end
            2:
            begin
                push_any(MODE_SET_COUNT, c);
                push_any(MODE_ALARM_ABS, c + k);
                push_ticks((k + 1) * span + $urandom_range(0, 2));
            end
            3:
            begin
                t = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 86399)
                                                : $urandom_range(86390, 86399);
                push_cmd(MODE_SET_TIME, $urandom, 5'(t / 3600), 6'((t % 3600) / 60),
                         6'(t % 60));
                t = t + k;
                push_cmd(MODE_ALARM_TOD, $urandom, 5'(t / 3600), 6'((t % 3600) / 60),
                         6'(t % 60));
                push_ticks((k + 1) * span + $urandom_range(0, 2));
            end
            4:
            begin
                c = 32'hFFFF_FFFF - $urandom_range(0, 3);
                push_any(MODE_SET_COUNT, c);
                push_any(MODE_ALARM_ABS, c + k);
                push_ticks((k + 1) * span + $urandom_range(0, 2));
            end
            5:
            begin
                push_any(MODE_CLEAR_FLAG, $urandom);
                push_ticks($urandom_range(1, 2 * span));
            end
            6, 7:
            begin
                repeat ($urandom_range(1, 6)) push_any(3'($urandom_range(0, 7)), $urandom);
            end
            8:
            begin
                push_any(MODE_SET_COUNT, c);
                push_any(MODE_ALARM_REL, '0);
                push_ticks(k * span);
                push_any(MODE_SET_COUNT, c);
            end
            default:
            begin
                push_any(MODE_SET_COUNT, c);
                push_any(MODE_ALARM_TOD, $urandom);
                push_ticks($urandom_range(1, 3) * span);
            end
        endcase
    endfunction

    task automatic write_reload(input logic [PRESCALE_W-1:0] v);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        rtc_reload = v;
    endtask

    task automatic wait_idle();
        while (clock_cmds.size() != 0 || in_valid || clock_reports_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (12) @(posedge clk);
    endtask

    function automatic void check_field(input string name, input logic [COUNT_W-1:0] want,
                                        input logic [COUNT_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_count++;
        end
    endfunction

    // command driver
    always @(negedge clk)
    begin
        logic       hold_valid;
        clock_cmd_t next_cmd;
        hold_valid = in_valid && !in_taken;
        in_taken = 1'b0;
        if (!hold_valid && rst_n)
        begin
            if (feed_gap > 0 && !fast_feed)
            begin
                feed_gap--;
            end
            else if (clock_cmds.size() > 0)
            begin
                next_cmd = clock_cmds.pop_front();
                mode <= next_cmd.mode;
                value <= next_cmd.value;
                hour_in <= next_cmd.hour;
                minute_in <= next_cmd.minute;
                second_in <= next_cmd.second;
                hold_valid = 1'b1;
                feed_gap = fast_feed ? 0 : pick_gap(feed_calm);
            end
        end
        in_valid <= hold_valid;
    end

    // report backpressure
    always @(negedge clk)
    begin
        if (fast_feed)
        begin
            out_ready <= 1'b1;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            out_ready <= 1'b0;
            stall_left--;
        end
        else
        begin
            out_ready <= 1'b1;
            stall_left = pick_gap(sink_calm);
        end
    end

    // predict on each command transfer
    always @(posedge clk)
    begin
        clock_cmd_t cmd;
        if (rst_n && in_valid && in_ready)
        begin
            cmd.mode = mode;
            cmd.value = value;
            cmd.hour = hour_in;
            cmd.minute = minute_in;
            cmd.second = second_in;
            clock_reports_due.push_back(rtc_advance(cmd));
            in_taken = 1'b1;
        end
    end

    // check each report transfer
    always @(posedge clk)
    begin
        clock_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (clock_reports_due.size() == 0)
            begin
                $error("report with none pending: count_now %0d", count_now);
                fault_count++;
            end
            else
            begin
                want = clock_reports_due.pop_front();
                check_field("count_now", want.count, count_now);
                check_field("hour_out", 32'(want.hour), 32'(hour_out));
                check_field("minute_out", 32'(want.minute), 32'(minute_out));
                check_field("second_out", 32'(want.second), 32'(second_out));
                check_field("seconds_until_alarm", want.to_alarm, seconds_until_alarm);
                check_field("alarm_flag_out", 32'(want.flag), 32'(alarm_flag_out));
                check_field("alarm_hit", 32'(want.hit), 32'(alarm_hit));
            end
        end
    end

    initial
    begin
        logic [PRESCALE_W-1:0] reloads[6];
        reloads = '{20'd0, 20'd3, 20'd1, 20'($urandom_range(2, 7)), 20'd5, 20'hFFFFF};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset state, then run the prescaler down from its reset value
        write_reload(20'd0);
        push_cmd(MODE_UNUSED, 32'hFFFF_FFFF, 5'd31, 6'd63, 6'd63);
        push_cmd(MODE_CLEAR_FLAG, '0, '0, '0, '0);
        push_cmd(MODE_SET_TIME, '0, 5'd23, 6'd59, 6'd59);
        push_cmd(MODE_SET_TIME, '0, 5'd31, 6'd63, 6'd63);
        push_cmd(MODE_ALARM_ABS, 32'd115443, '0, '0, '0);
        push_cmd(MODE_SET_COUNT, 32'hFFFF_FFFF, '0, '0, '0);
        push_cmd(MODE_ALARM_ABS, '0, '0, '0, '0);
        push_cmd(MODE_SET_COUNT, '0, '0, '0, '0);
        push_cmd(MODE_ALARM_REL, 32'd1, '0, '0, '0);
        fast_feed = 1'b1;
        push_ticks(32768);
        wait_idle();
        fast_feed = 1'b0;

        // wrap, hits and the alarm modes with one tick per second
        push_cmd(MODE_SET_COUNT, 32'hFFFF_FFFD, '0, '0, '0);
        push_cmd(MODE_ALARM_ABS, 32'hFFFF_FFFF, '0, '0, '0);
        push_ticks(3);
        push_cmd(MODE_CLEAR_FLAG, '0, '0, '0, '0);
        push_cmd(MODE_ALARM_REL, 32'hFFFF_FFFF, '0, '0, '0);
        push_cmd(MODE_SET_COUNT, 32'd100, '0, '0, '0);
        push_cmd(MODE_ALARM_REL, 32'hFFFF_FFFF, '0, '0, '0);
        push_cmd(MODE_SET_TIME, '0, '0, '0, '0);
        push_cmd(MODE_ALARM_TOD, '0, '0, '0, '0);
        push_cmd(MODE_SET_TIME, '0, 5'd23, 6'd59, 6'd59);
        push_cmd(MODE_ALARM_TOD, '0, '0, '0, '0);
        push_ticks(1);
        push_cmd(MODE_SET_COUNT, 32'hFFFF_FFF5, '0, '0, '0);
        push_cmd(MODE_ALARM_TOD, '0, 5'd31, 6'd63, 6'd63);
        push_cmd(MODE_ALARM_TOD, '0, '0, '0, 6'd1);
        push_cmd(MODE_CLEAR_FLAG, '0, '0, '0, '0);
        push_ticks(2);
        wait_idle();

        foreach (reloads[i])
        begin
            write_reload(reloads[i]);
            cmds_queued = 0;
            while (cmds_queued < 140)
            begin
                push_scenario(reloads[i]);
            end
            wait_idle();
        end

        if (fault_count == 0 && clock_reports_due.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/rtcsc_pkg.sv
rtl/core/rtc_seconds_counter_alarm_top.sv
rtl/core/rtcsc_checker.sv
tb/tb.sv
